>>> rtl/core/compressed_rtf_lz_decompressor_macros.svh
// assertion macros used by the checker file of the decompressor
// depends on nothing; included by bare file name
`ifndef COMPRESSED_RTF_LZ_DECOMPRESSOR_MACROS_SVH
`define COMPRESSED_RTF_LZ_DECOMPRESSOR_MACROS_SVH

// same-cycle implication, held off during reset
`define CRTFLZ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define CRTFLZ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/crtflz_pkg.sv
// shared types, constants and the preset dictionary of the compressed-rtf decompressor
// depends on nothing
package crtflz_pkg;

	localparam int WINDOW_DEPTH = 4096;
	localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
	localparam int FILL_W       = ADDR_W + 1;
	localparam int DICT_LENGTH  = 207;
	localparam int HEADER_LEN   = 16;
	localparam int CNT_W        = 33;
	localparam int LEN_W        = 5;
	localparam int LEN_BIAS     = 2;
	localparam int LIMIT_SLACK  = 4;
	localparam logic [3:0] FLAG_EXPECT = 4'd8;

	// preset window contents, first character in the top byte
	localparam logic [DICT_LENGTH*8-1:0] DICT_TEXT = {
		"{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}",
		"{\\f0\\fnil \\froman \\fswiss \\fmodern \\fscrip",
		"t \\fdecor MS Sans SerifSymbolArialTimes Ne",
		"w RomanCourier{\\colortbl\\red0\\green0\\blue0",
		"\015\012\\par \\pard\\plain\\f0\\fs20\\b\\i\\u\\tab",
		"\\tx"
	};

	typedef enum logic [2:0] {
		PH_START,
		PH_DONE,
		PH_HEADER,
		PH_FLAG,
		PH_REF_HI,
		PH_REF_LO,
		PH_LITERAL
	} parse_phase_t;

	typedef struct packed {
		logic              load;
		logic              stream_init;
		logic              literal;
		logic [7:0]        lit_byte;
		logic [ADDR_W-1:0] src;
		logic [LEN_W-1:0]  len;
		logic              done;
	} copy_job_t;

	// window entry value right after a stream start
	function automatic logic [7:0] dict_byte(input logic [ADDR_W-1:0] addr);
		logic [7:0] b;
		b = 8'h00;
		if (addr < ADDR_W'(DICT_LENGTH))
			b = DICT_TEXT[(DICT_LENGTH - 1 - int'(addr)) * 8 +: 8];
		return b;
	endfunction

endpackage

>>> rtl/core/crtflz_copy.sv
// copy sequencer: history window memory, read stage with forwarding, output register
// depends on crtflz_pkg
module crtflz_copy
	import crtflz_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  copy_job_t job,
	output logic      busy,
	output logic      emit_valid,
	input  logic      emit_stall,
	output logic [7:0] out_byte,
	output logic      last_of_run,
	output logic      stream_done
);

	logic [7:0] window_mem [WINDOW_DEPTH];

	logic              job_busy_q;
	logic [ADDR_W-1:0] job_src_q;
	logic [LEN_W-1:0]  job_cnt_q;
	logic              job_lit_q;
	logic [7:0]        job_lit_byte_q;
	logic              job_done_q;

	logic [ADDR_W-1:0] wr_pos_q;
	logic [FILL_W-1:0] fill_q;

	logic              valid_s1;
	logic              live_s1;
	logic [ADDR_W-1:0] waddr_s1;
	logic              last_s1;
	logic              done_s1;
	logic              use_mem_s1;
	logic [7:0]        alt_s1;
	logic [7:0]        rdata_s1;

	logic              emit_valid_q;
	logic [7:0]        out_byte_q;
	logic              last_q;
	logic              done_q;

	logic [7:0]        s1_value;
	logic              s1_adv;
	logic              issue;
	logic              fwd;
	logic              written;
	logic [ADDR_W-1:0] rd_off;

	assign s1_value = use_mem_s1 ? rdata_s1 : alt_s1;
	assign s1_adv   = valid_s1 && (!emit_valid_q || !emit_stall);
	assign issue    = job_busy_q && (!valid_s1 || s1_adv);
	// same entry being written back this cycle
	assign fwd      = valid_s1 && live_s1 && (job_src_q == waddr_s1);
	// entries are written in order from the dictionary end, so distance tells
	assign rd_off   = job_src_q - ADDR_W'(DICT_LENGTH);
	assign written  = ({1'b0, rd_off} < fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_busy_q   <= 1'b0;
			wr_pos_q     <= ADDR_W'(DICT_LENGTH);
			fill_q       <= '0;
			valid_s1     <= 1'b0;
			live_s1      <= 1'b0;
			emit_valid_q <= 1'b0;
		end else begin
			if (job.load) begin
				job_busy_q <= 1'b1;
			end else if (issue && job_cnt_q == LEN_W'(1)) begin
				job_busy_q <= 1'b0;
			end
			if (job.stream_init) begin
				wr_pos_q <= ADDR_W'(DICT_LENGTH);
				fill_q   <= '0;
			end else if (issue) begin
				wr_pos_q <= wr_pos_q + 1'b1;
				if (fill_q != FILL_W'(WINDOW_DEPTH))
					fill_q <= fill_q + 1'b1;
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (job.stream_init) begin
				live_s1 <= 1'b0;
			end else if (issue) begin
				live_s1 <= 1'b1;
			end
			if (s1_adv) begin
				emit_valid_q <= 1'b1;
			end else if (!emit_stall) begin
				emit_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job.load) begin
			job_src_q      <= job.src;
			job_cnt_q      <= job.len;
			job_lit_q      <= job.literal;
			job_lit_byte_q <= job.lit_byte;
			job_done_q     <= job.done;
		end else if (issue) begin
			job_src_q <= job_src_q + 1'b1;
			job_cnt_q <= job_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			waddr_s1   <= wr_pos_q;
			last_s1    <= (job_cnt_q == LEN_W'(1));
			done_s1    <= job_done_q;
			use_mem_s1 <= !job_lit_q && !fwd && written;
			if (job_lit_q) begin
				alt_s1 <= job_lit_byte_q;
			end else if (fwd) begin
				alt_s1 <= s1_value;
			end else begin
				alt_s1 <= dict_byte(job_src_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue)
			rdata_s1 <= window_mem[job_src_q];
	end

	always_ff @(posedge clk) begin
		if (s1_adv)
			window_mem[waddr_s1] <= s1_value;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_byte_q <= s1_value;
			last_q     <= last_s1;
			done_q     <= done_s1;
		end
	end

	assign busy        = job_busy_q;
	assign emit_valid  = emit_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;
	assign stream_done = done_q;

endmodule

>>> rtl/core/compressed_rtf_lz_decompressor.sv
// compressed-rtf (lzfu) decompressor top level: stream parser and size limits
// depends on crtflz_pkg and crtflz_copy
//
// usage
// - feed channel (feed_valid / feed_stall) takes one compressed byte per request;
//   stream_start marks the first header byte of a new stream
// - emit channel (emit_valid / emit_stall) gives one decompressed byte per request,
//   last_of_run marks the final byte caused by one feed request, stream_done says
//   the size limits were reached and later feed bytes are dropped
// - header, flag and first reference bytes give no output and do not raise feed_stall
// - a literal holds feed_stall until the copy sequencer has issued it
// - a reference of n bytes (2..17) holds feed_stall until all n reads are issued,
//   one read per cycle unless emit stalls, on the read port of the 4096-byte window
// - the first output byte passes the job, read stage and output registers to emit
// - a stall on emit backs up the output register and read stage, then the copy
//   sequencer and finally the feed channel; nothing is dropped
// - after reset the block ignores bytes until a stream start; the window needs
//   no clearing pass, a fill count tells written entries from preset ones
module compressed_rtf_lz_decompressor
	import crtflz_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       feed_valid,
	output logic       feed_stall,
	input  logic [7:0] data_byte,
	input  logic       stream_start,
	output logic       emit_valid,
	input  logic       emit_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       stream_done
);

	// stream header and counters
	logic [4:0]       header_cnt_q;
	logic [31:0]      packed_q;
	logic [31:0]      unpacked_q;
	logic [CNT_W-1:0] consumed_q;
	logic [CNT_W-1:0] emitted_q;
	// flag byte walk
	logic [7:0]       flag_bits_q;
	logic [3:0]       flag_idx_q;
	logic [7:0]       ref_high_q;
	logic             ref_pend_q;
	logic             finished_q;

	logic             accept;
	logic             copy_busy;
	parse_phase_t     phase;
	logic [1:0]       cons_inc;
	logic [LEN_W-1:0] emit_inc;
	logic [LEN_W-1:0] ref_len;
	logic [CNT_W-1:0] cons_new;
	logic [CNT_W-1:0] emit_new;
	logic             limit_hit;
	copy_job_t        job;

	// feed is held off only while the copy sequencer still has reads to issue
	assign feed_stall = copy_busy;
	assign accept     = feed_valid && !feed_stall;

	// what the incoming byte means
	always_comb begin
		priority if (stream_start)
			phase = PH_START;
		else if (finished_q)
			phase = PH_DONE;
		else if (header_cnt_q != 5'(HEADER_LEN))
			phase = PH_HEADER;
		else if (flag_idx_q == FLAG_EXPECT)
			phase = PH_FLAG;
		else if (ref_pend_q)
			phase = PH_REF_LO;
		else if (flag_bits_q[flag_idx_q[2:0]])
			phase = PH_REF_HI;
		else
			phase = PH_LITERAL;
	end

	// reference word is big-endian: 12-bit offset, 4-bit length minus two
	assign ref_len = LEN_W'(data_byte[3:0]) + LEN_W'(LEN_BIAS);

	always_comb begin
		cons_inc = 2'd0;
		emit_inc = '0;
		unique case (phase)
			PH_HEADER:  cons_inc = 2'd1;
			PH_FLAG:    cons_inc = 2'd1;
			PH_REF_LO: begin
				cons_inc = 2'd2;
				emit_inc = ref_len;
			end
			PH_LITERAL: begin
				cons_inc = 2'd1;
				emit_inc = LEN_W'(1);
			end
			default: begin
				cons_inc = 2'd0;
				emit_inc = '0;
			end
		endcase
	end

	// counters never wrap; the limit sum is one bit wider than the size field
	assign cons_new  = consumed_q + CNT_W'(cons_inc);
	assign emit_new  = emitted_q + CNT_W'(emit_inc);
	assign limit_hit = (cons_new >= ({1'b0, packed_q} + CNT_W'(LIMIT_SLACK))) ||
	                   (emit_new >= {1'b0, unpacked_q});

	always_comb begin
		job.load        = accept && (phase == PH_REF_LO || phase == PH_LITERAL);
		job.stream_init = accept && (phase == PH_START);
		job.literal     = (phase == PH_LITERAL);
		job.lit_byte    = data_byte;
		job.src         = {ref_high_q, data_byte[7:4]};
		job.len         = (phase == PH_LITERAL) ? LEN_W'(1) : ref_len;
		job.done        = limit_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_cnt_q <= '0;
			packed_q     <= '0;
			unpacked_q   <= '0;
			consumed_q   <= '0;
			emitted_q    <= '0;
			flag_bits_q  <= '0;
			flag_idx_q   <= FLAG_EXPECT;
			ref_high_q   <= '0;
			ref_pend_q   <= 1'b0;
			finished_q   <= 1'b1;
		end else if (accept) begin
			unique case (phase)
				PH_START: begin
					// start byte is header byte zero
					header_cnt_q <= 5'd1;
					packed_q     <= {24'h0, data_byte};
					unpacked_q   <= '0;
					consumed_q   <= CNT_W'(1);
					emitted_q    <= '0;
					flag_bits_q  <= '0;
					flag_idx_q   <= FLAG_EXPECT;
					ref_high_q   <= '0;
					ref_pend_q   <= 1'b0;
					finished_q   <= 1'b0;
				end
				PH_HEADER: begin
					if (header_cnt_q[4:2] == 3'd0)
						packed_q[{header_cnt_q[1:0], 3'b000} +: 8] <= data_byte;
					else if (header_cnt_q[4:2] == 3'd1)
						unpacked_q[{header_cnt_q[1:0], 3'b000} +: 8] <= data_byte;
					header_cnt_q <= header_cnt_q + 1'b1;
					consumed_q   <= cons_new;
					// magic and crc are skipped, limits checked at the header end
					if (header_cnt_q == 5'(HEADER_LEN - 1))
						finished_q <= limit_hit;
				end
				PH_FLAG: begin
					flag_bits_q <= data_byte;
					flag_idx_q  <= '0;
					consumed_q  <= cons_new;
					finished_q  <= limit_hit;
				end
				PH_REF_HI: begin
					ref_high_q <= data_byte;
					ref_pend_q <= 1'b1;
				end
				PH_REF_LO: begin
					// a reference is copied in full even past the limits
					ref_pend_q <= 1'b0;
					consumed_q <= cons_new;
					emitted_q  <= emit_new;
					flag_idx_q <= flag_idx_q + 1'b1;
					finished_q <= limit_hit;
				end
				PH_LITERAL: begin
					// 0xff is plain data here
					consumed_q <= cons_new;
					emitted_q  <= emit_new;
					flag_idx_q <= flag_idx_q + 1'b1;
					finished_q <= limit_hit;
				end
				PH_DONE: begin
					// bytes after the end are dropped
					finished_q <= 1'b1;
				end
				default: begin
					finished_q <= finished_q;
				end
			endcase
		end
	end

	crtflz_copy u_copy (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (job),
		.busy        (copy_busy),
		.emit_valid  (emit_valid),
		.emit_stall  (emit_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.stream_done (stream_done)
	);

endmodule

>>> rtl/core/crtflz_checker.sv
// port-level checks on the emit channel of the decompressor, bound to the top level
// depends on compressed_rtf_lz_decompressor_macros.svh
`include "compressed_rtf_lz_decompressor_macros.svh"

module crtflz_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       emit_valid,
	input logic       emit_stall,
	input logic [7:0] out_byte,
	input logic       last_of_run,
	input logic       stream_done
);

	// stalled output holds
	`CRTFLZ_ASSERT_NEXT(a_emit_hold, clk, arst_n, emit_valid && emit_stall, emit_valid && $stable(out_byte) && $stable(last_of_run) && $stable(stream_done), "emit changed under stall")

	// a run that is not finished has its next byte ready right away
	`CRTFLZ_ASSERT_NEXT(a_run_continues, clk, arst_n, emit_valid && !emit_stall && !last_of_run, emit_valid, "gap inside an output run")

	// every byte of one run carries the same done flag
	`CRTFLZ_ASSERT_NEXT(a_run_done_same, clk, arst_n, emit_valid && !emit_stall && !last_of_run, stream_done == $past(stream_done), "done flag changed inside a run")

endmodule

bind compressed_rtf_lz_decompressor crtflz_checker u_crtflz_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.emit_valid  (emit_valid),
	.emit_stall  (emit_stall),
	.out_byte    (out_byte),
	.last_of_run (last_of_run),
	.stream_done (stream_done)
);
